@@ sv/uts_pkg.sv @@
// uts_pkg: shared types and constants of the utf-8 text sanitizer
// no dependencies; imported by uts_decode, uts_queue, the top level and the bench

package uts_pkg;

   localparam int unsigned MaxBurst   = 4;   // most bytes one input beat can release
   localparam int unsigned QueueDepth = 8;   // output queue entries, twice the burst
   localparam int unsigned QueueAw    = $clog2(QueueDepth);
   localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

   localparam logic [7:0] QMARK = 8'h3F;
   localparam logic [7:0] SPACE = 8'h20;
   localparam logic [7:0] TAB   = 8'h09;
   localparam logic [7:0] LF    = 8'h0A;
   localparam logic [7:0] CR    = 8'h0D;
   localparam logic [7:0] DEL   = 8'h7F;

   // bytes released into the output queue by one accepted input beat
   typedef struct packed {
      logic [2:0]      num;     // 0..4
      logic            last;    // end-of-string flag for the final released byte
      logic [3:0][7:0] bytes;   // bytes[0] goes out first
   } uts_push_type;

endpackage

@@ sv/uts_decode.sv @@
// uts_decode: sequence state and byte classification for one input beat
// depends on uts_pkg; feeds uts_queue with the bytes each beat releases

module uts_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  logic                  csr_write_en,
   input  logic                  csr_write_data,
   output uts_pkg::uts_push_type push
);
   import uts_pkg::*;

   logic            crlf_ff;
   logic [2:0]      seq_len_ff, seq_len_in;
   logic [1:0]      held_cnt_ff, held_cnt_in;
   logic [7:0]      held_ff [3];
   logic            hold_wr;
   logic [1:0]      hold_idx;
   logic [2:0]      cnt_next;
   logic [3:0][7:0] buf_b;
   logic            cont_bad;
   logic            bad;
   logic            is_ctrl;
   logic [7:0]      ascii_out;
   uts_push_type    push_c;

   function automatic logic is_cont(input logic [7:0] x);
      return x[7:6] == 2'b10;
   endfunction

   // assemble the completed sequence with the current beat at its end
   always_comb begin
      buf_b[0] = held_ff[0];
      buf_b[1] = (seq_len_ff == 3'd2) ? in_byte : held_ff[1];
      buf_b[2] = (seq_len_ff == 3'd3) ? in_byte : held_ff[2];
      buf_b[3] = in_byte;
   end

   always_comb begin
      cont_bad = !is_cont(buf_b[1]);
      if (seq_len_ff >= 3'd3 && !is_cont(buf_b[2])) cont_bad = 1'b1;
      if (seq_len_ff == 3'd4 && !is_cont(buf_b[3])) cont_bad = 1'b1;
      bad = cont_bad;
      case (seq_len_ff)
         3'd2: begin
            if (buf_b[0] < 8'hC2) bad = 1'b1;
            if (buf_b[0] == 8'hC2 && buf_b[1] <= 8'hB2) bad = 1'b1;
         end
         3'd3: begin
            if (buf_b[0] == 8'hE0 && buf_b[1] < 8'hA0) bad = 1'b1;
            // bidi direction controls
            if (buf_b[0] == 8'hE2 && buf_b[1] == 8'h80 &&
                ((buf_b[2] >= 8'h8C && buf_b[2] <= 8'h8F) ||
                 (buf_b[2] >= 8'hA8 && buf_b[2] <= 8'hAE))) bad = 1'b1;
            if (buf_b[0] == 8'hE2 && buf_b[1] == 8'h81 &&
                (buf_b[2] == 8'hA0 ||
                 (buf_b[2] >= 8'hAA && buf_b[2] <= 8'hAF))) bad = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      is_ctrl = (in_byte <= 8'h1F || in_byte == DEL) &&
                in_byte != TAB && in_byte != LF && in_byte != CR;
      ascii_out = in_byte;
      if (is_ctrl) ascii_out = QMARK;
      if (crlf_ff && (in_byte == LF || in_byte == CR)) ascii_out = SPACE;
   end

   always_comb begin
      cnt_next    = {1'b0, held_cnt_ff} + 3'd1;
      push_c      = '0;
      seq_len_in  = seq_len_ff;
      held_cnt_in = held_cnt_ff;
      hold_wr     = 1'b0;
      hold_idx    = held_cnt_ff;
      if (seq_len_ff == 3'd0) begin
         if (!in_byte[7]) begin
            push_c.num      = 3'd1;
            push_c.last     = in_last;
            push_c.bytes[0] = ascii_out;
         end else if (in_byte >= 8'hC0 && in_byte <= 8'hF7) begin
            if (in_last) begin
               push_c.num      = 3'd1;
               push_c.last     = 1'b1;
               push_c.bytes[0] = QMARK;
            end else begin
               hold_wr     = 1'b1;
               hold_idx    = 2'd0;
               held_cnt_in = 2'd1;
               if (in_byte <= 8'hDF)      seq_len_in = 3'd2;
               else if (in_byte <= 8'hEF) seq_len_in = 3'd3;
               else                       seq_len_in = 3'd4;
            end
         end else begin
            // stray continuation or f8..ff lead
            push_c.num      = 3'd1;
            push_c.last     = in_last;
            push_c.bytes[0] = QMARK;
         end
      end else if (held_cnt_ff == 2'd0 || {1'b0, held_cnt_ff} >= seq_len_ff ||
                   seq_len_ff > 3'd4) begin
         // broken state: close it
         seq_len_in      = 3'd0;
         held_cnt_in     = 2'd0;
         push_c.num      = 3'd1;
         push_c.last     = in_last;
         push_c.bytes[0] = QMARK;
      end else if (cnt_next < seq_len_ff) begin
         if (in_last) begin
            // cut off by end of string
            seq_len_in  = 3'd0;
            held_cnt_in = 2'd0;
            push_c.num  = cnt_next;
            push_c.last = 1'b1;
            for (int k = 0; k < MaxBurst; k++) push_c.bytes[k] = QMARK;
         end else begin
            hold_wr     = 1'b1;
            held_cnt_in = cnt_next[1:0];
         end
      end else begin
         seq_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         push_c.num  = seq_len_ff;
         push_c.last = in_last;
         for (int k = 0; k < MaxBurst; k++) push_c.bytes[k] = bad ? QMARK : buf_b[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_ff     <= 1'b0;
         seq_len_ff  <= 3'd0;
         held_cnt_ff <= 2'd0;
      end else begin
         if (csr_write_en) crlf_ff <= csr_write_data;
         if (take) begin
            seq_len_ff  <= seq_len_in;
            held_cnt_ff <= held_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && hold_wr) held_ff[hold_idx] <= in_byte;
   end

   assign push = take ? push_c : '0;

endmodule

@@ sv/uts_queue.sv @@
// uts_queue: output queue in flip-flops, up to four writes and one read a cycle
// depends on uts_pkg; drives the rsp_ side of the top level

module uts_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  uts_pkg::uts_push_type push,
   output logic                  space_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last
);
   import uts_pkg::*;

   logic [7:0]         data_ff [QueueDepth];
   logic               last_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCw-1:0] count_ff, count_in;
   logic               pop;

   assign rsp_valid    = count_ff != '0;
   assign pop          = rsp_valid && rsp_ready;
   assign rsp_out_byte = data_ff[rd_ptr_ff];
   assign rsp_out_last = last_ff[rd_ptr_ff];
   // room for a full burst, judged on the registered count
   assign space_ok     = count_ff <= QueueCw'(QueueDepth - MaxBurst);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueueAw'(push.num);
      rd_ptr_in = rd_ptr_ff + QueueAw'(pop);
      count_in  = count_ff + QueueCw'(push.num) - QueueCw'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxBurst; k++) begin
         if (3'(k) < push.num) begin
            data_ff[wr_ptr_ff + QueueAw'(k)] <= push.bytes[k];
            last_ff[wr_ptr_ff + QueueAw'(k)] <= (3'(k) + 3'd1 == push.num) && push.last;
         end
      end
   end

endmodule

@@ sv/utf8_text_sanitizer_top.sv @@
// utf8_text_sanitizer_top: cleans a utf-8 text stream one byte beat at a time
// depends on uts_pkg, uts_decode, uts_queue
//
//   channel  dir  ports                                     moves
//   req      in   req_valid req_ready req_in_byte req_in_last  raw byte beat
//   rsp      out  rsp_valid rsp_ready rsp_out_byte rsp_out_last  cleaned byte beat
//   csr      in   csr_write_en csr_write_data               crlf_to_space bit
//
// one req beat a cycle while the 8-entry output queue has room for a 4-byte burst
// a beat's bytes reach the queue at the next edge
// multibyte sequences are held in decode and released together when complete
// rsp stalls only back up req once the queue holds more than four bytes
// synchronous reset empties the queue, closes any open sequence, clears crlf mode

module utf8_text_sanitizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_write_en,
   input  logic       csr_write_data
);
   import uts_pkg::*;

   uts_push_type push;
   logic         take;

   assign take = req_valid && req_ready;

   uts_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .in_byte        (req_in_byte),
      .in_last        (req_in_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push)
   );

   uts_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .space_ok     (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

@@ sv/uts_checker.sv @@
// uts_checker: port-level checks of the sanitizer, bound to the top level
// depends only on the ports of utf8_text_sanitizer_top

module uts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("rsp beat changed while stalled");

   // reset leaves the queue empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

   // no control byte other than tab, lf and cr ever leaves the block
   a_no_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte != 8'h7F &&
                    (rsp_out_byte >= 8'h20 || rsp_out_byte == 8'h09 ||
                     rsp_out_byte == 8'h0A || rsp_out_byte == 8'h0D))
      else $error("control byte on rsp");

   // with nothing queued and no beat taken, nothing appears
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("rsp beat without a req beat");

endmodule

bind utf8_text_sanitizer_top uts_checker u_uts_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

@@ tb/sv/utf8_text_sanitizer_top_tb.sv @@
// utf8_text_sanitizer_top_tb: self-checking bench for the utf-8 text sanitizer
// depends on uts_pkg and utf8_text_sanitizer_top; predicts every cleaned beat in-line

module utf8_text_sanitizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uts_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } clean_beat_type;

   typedef enum int {
      UNIT_ASCII,
      UNIT_TWO,
      UNIT_THREE,
      UNIT_DIRECTION,
      UNIT_FOUR,
      UNIT_OVERLONG,
      UNIT_BROKEN,
      UNIT_STRAY,
      UNIT_NOISE
   } text_unit_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_in_last    = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_write_en   = 1'b0;
   logic       csr_write_data = 1'b0;

   // predictor state
   logic        crlf_mode = 1'b0;
   logic [7:0]  held_bytes [3];
   int unsigned held_cnt = 0;
   int unsigned open_len = 0;

   clean_beat_type clean_bytes_q [$];
   logic [7:0]  text_q [$];
   int unsigned error_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned burst_left  = 0;
   bit          hold_request = 0;

   utf8_text_sanitizer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic bit is_cont(logic [7:0] x);
      return x[7:6] == 2'b10;
   endfunction

   function automatic bit seq_is_rejected(logic [7:0] seq [4], int unsigned n);
      for (int k = 1; k < n; k++)
         if (!is_cont(seq[k]))
            return 1;
      if (n == 2)
         return seq[0] < 8'hC2 || (seq[0] == 8'hC2 && seq[1] <= 8'hB2);
      if (n == 3) begin
         if (seq[0] == 8'hE0 && seq[1] < 8'hA0)
            return 1;
         // bidi and zero-width direction controls
         if (seq[0] == 8'hE2 && seq[1] == 8'h80 &&
             ((seq[2] >= 8'h8C && seq[2] <= 8'h8F) || (seq[2] >= 8'hA8 && seq[2] <= 8'hAE)))
            return 1;
         if (seq[0] == 8'hE2 && seq[1] == 8'h81 &&
             (seq[2] == 8'hA0 || (seq[2] >= 8'hAA && seq[2] <= 8'hAF)))
            return 1;
      end
      return 0;
   endfunction

   function automatic void predict_clean_bytes(logic [7:0] b, logic last);
      logic [7:0]  seq [4];
      logic [7:0]  o;
      int unsigned cnt;
      bit          bad;
      if (open_len == 0) begin
         if (b <= DEL) begin
            o = b;
            if ((b <= 8'h1F || b == DEL) && b != TAB && b != LF && b != CR)
               o = QMARK;
            if (crlf_mode && (b == LF || b == CR))
               o = SPACE;
            clean_bytes_q.push_back('{data: o, last: last});
         end else if (b < 8'hC0 || b >= 8'hF8) begin
            clean_bytes_q.push_back('{data: QMARK, last: last});
         end else if (last) begin
            clean_bytes_q.push_back('{data: QMARK, last: 1'b1});
         end else begin
            held_bytes[0] = b;
            held_cnt = 1;
            open_len = (b >= 8'hF0) ? 4 : (b >= 8'hE0) ? 3 : 2;
         end
         return;
      end
      for (int k = 0; k < held_cnt; k++)
         seq[k] = held_bytes[k];
      seq[held_cnt] = b;
      cnt = held_cnt + 1;
      if (cnt < open_len) begin
         if (last) begin
            // string ended inside the sequence
            for (int k = 0; k < cnt; k++)
               clean_bytes_q.push_back('{data: QMARK, last: (k + 1 == cnt)});
            open_len = 0;
            held_cnt = 0;
         end else begin
            held_bytes[cnt - 1] = b;
            held_cnt = cnt;
         end
         return;
      end
      bad = seq_is_rejected(seq, open_len);
      for (int k = 0; k < open_len; k++)
         clean_bytes_q.push_back('{data: bad ? QMARK : seq[k],
                                   last: (k + 1 == open_len) ? last : 1'b0});
      open_len = 0;
      held_cnt = 0;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      clean_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (clean_bytes_q.size() == 0) begin
            report_mismatch($sformatf("beat %02h/%0b with nothing expected",
                                      rsp_out_byte, rsp_out_last));
         end else begin
            want = clean_bytes_q.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.data));
            if (rsp_out_last !== want.last)
               report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                         rsp_out_last, want.last, want.data));
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      int unsigned stall_mode;
      int unsigned mode_cycles;
      int unsigned phase;
      stall_mode = 0;
      mode_cycles = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            if (mode_cycles == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_cycles = $urandom_range(16, 64);
            end
            mode_cycles--;
            phase++;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= (phase % 3 == 0);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   task automatic send_beat(logic [7:0] b, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      predict_clean_bytes(b, last);
   endtask

   task automatic send_text();
      for (int k = 0; k < text_q.size(); k++)
         send_beat(text_q[k], k == text_q.size() - 1);
      beats_sent += text_q.size();
      text_q.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (clean_bytes_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_crlf_mode(logic value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      crlf_mode = value;
   endtask

   task automatic append_unit();
      text_unit_type kind;
      logic [7:0]  lead;
      logic [7:0]  mid;
      int unsigned len;
      kind = text_unit_type'($urandom_range(0, UNIT_NOISE));
      if ($urandom_range(0, 3) == 0)
         kind = UNIT_ASCII;
      case (kind)
         UNIT_ASCII: begin
            lead = 8'($urandom_range(0, 8'h7F));
            if ($urandom_range(0, 2) == 0)
               lead = lead & 8'h1F;
            text_q.push_back(lead);
         end
         UNIT_TWO: begin
            text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         UNIT_THREE: begin
            text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         UNIT_DIRECTION: begin
            mid = $urandom_range(0, 1) ? 8'h80 : 8'h81;
            text_q.push_back(8'hE2);
            text_q.push_back(mid);
            case ($urandom_range(0, 3))
               0: text_q.push_back(8'($urandom_range(8'h8C, 8'h8F)));
               1: text_q.push_back(8'($urandom_range(8'hA8, 8'hAF)));
               2: text_q.push_back(8'hA0);
               default: text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            endcase
         end
         UNIT_FOUR: begin
            text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         UNIT_OVERLONG: begin
            case ($urandom_range(0, 2))
               0: text_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
               1: text_q.push_back(8'hC2);
               default: begin
                  text_q.push_back(8'hE0);
                  text_q.push_back(8'($urandom_range(8'h80, 8'hA1)));
               end
            endcase
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         UNIT_BROKEN: begin
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            len = (lead >= 8'hF0) ? 4 : (lead >= 8'hE0) ? 3 : 2;
            text_q.push_back(lead);
            repeat (len - 1)
               text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'hFF))
                                                     : 8'($urandom_range(8'h80, 8'hBF)));
         end
         UNIT_STRAY: begin
            text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
         end
         default: text_q.push_back(8'($urandom_range(0, 8'hFF)));
      endcase
   endtask

   task automatic test_control_bytes();
      text_q = '{8'h00, TAB, LF, CR, 8'h1F, DEL, 8'h7E};
      send_text();
   endtask

   task automatic test_sequences();
      // overlong and control-range leads, overlong three-byte, direction mark,
      // top four-byte, stray continuation, invalid lead, bad continuation
      text_q = '{8'hC1, 8'hBF, 8'hC2, 8'hB2, 8'hE0, 8'h9F, 8'hBF,
                 8'hE2, 8'h80, 8'hAE, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'h80, 8'hFF, 8'hE5, 8'h41, 8'h42};
      send_text();
      // string cut inside a sequence, and a lead alone as the last beat
      text_q = '{8'hE9, 8'hA0};
      send_text();
      text_q = '{8'hF0};
      send_text();
   endtask

   task automatic test_crlf_mode();
      write_crlf_mode(1'b1);
      text_q = '{LF, 8'h41, CR};
      send_text();
   endtask

   task automatic test_random_text(int unsigned count);
      int unsigned goal;
      logic [7:0]  lead;
      int unsigned len;
      goal = beats_sent + count;
      while (beats_sent < goal) begin
         repeat ($urandom_range(1, 6)) append_unit();
         if ($urandom_range(0, 4) == 0) begin
            // leave the final sequence unfinished
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            len = (lead >= 8'hF0) ? 4 : (lead >= 8'hE0) ? 3 : 2;
            text_q.push_back(lead);
            repeat ($urandom_range(0, len - 2))
               text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         send_text();
      end
   endtask

   task automatic test_backpressure();
      hold_request = 1;
      burst_left = 40;
      test_random_text(25);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_control_bytes();
      test_sequences();
      test_crlf_mode();
      test_random_text(20);
      test_backpressure();
      write_crlf_mode(1'b0);
      test_random_text(15);
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
